// ===== hdl/sffp_pkg.sv =====
// sffp_pkg: types and constants for the servo frame packer
// no dependencies; used by sffp_fletcher, servo_frame_fletcher_packer and tb_top

package sffp_pkg;

    localparam int unsigned SERVO_W     = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FRAME_SLOTS = 8;
    localparam int unsigned PAY_BYTES   = 2 * FRAME_SLOTS;
    localparam int unsigned FRAME_LEN   = PAY_BYTES + 4;
    localparam int unsigned IDX_W       = $clog2(FRAME_LEN);
    localparam int unsigned PAY_W       = $clog2(PAY_BYTES);

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hEE;

    // byte positions within the frame
    localparam logic [IDX_W-1:0] IDX_SYNC_FIRST  = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_SYNC_SECOND = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_PAY_FIRST   = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_PAY_LAST    = IDX_W'(PAY_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_SUM_A       = IDX_W'(PAY_BYTES + 2);
    localparam logic [IDX_W-1:0] IDX_SUM_B       = IDX_W'(PAY_BYTES + 3);

    typedef struct packed {
        logic [SERVO_W-1:0] servo_1;
        logic [SERVO_W-1:0] servo_2;
        logic [SERVO_W-1:0] servo_3;
        logic [SERVO_W-1:0] servo_4;
        logic [SERVO_W-1:0] servo_5;
        logic [SERVO_W-1:0] servo_6;
        logic [SERVO_W-1:0] servo_7;
        logic [SERVO_W-1:0] servo_8;
    } servo_set_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last_byte;
    } frame_out_t;

    // control from the sequencer to the checksum unit
    typedef struct packed {
        logic clear;
        logic accum;
    } sum_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } state_t;

endpackage

// ===== hdl/sffp_fletcher.sv =====
// sffp_fletcher: shared modulo-256 fletcher accumulator, one byte per cycle while ctrl.accum is set
// depends on sffp_pkg

module sffp_fletcher (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sffp_pkg::sum_ctrl_t       ctrl,
    input  logic [sffp_pkg::BYTE_W-1:0] data_byte,
    output logic [sffp_pkg::BYTE_W-1:0] sum_a,
    output logic [sffp_pkg::BYTE_W-1:0] sum_b
);
    import sffp_pkg::*;

    logic [BYTE_W-1:0] sum_a_reg, sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg, sum_b_next;

    always_comb begin
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        if (ctrl.clear) begin
            sum_a_next = '0;
            sum_b_next = '0;
        end else if (ctrl.accum) begin
            sum_a_next = sum_a_reg + data_byte;
            sum_b_next = sum_b_reg + sum_a_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end else begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    assign sum_a = sum_a_reg;
    assign sum_b = sum_b_reg;

endmodule

// ===== hdl/servo_frame_fletcher_packer.sv =====
// servo_frame_fletcher_packer: top level, byte sequencer and frame store
// depends on sffp_pkg and sffp_fletcher
//
// usage:
//   s_valid/s_ready/s_data carry one request: a set of eight 16-bit servo
//   pulse widths. m_valid/m_ready/m_data return the frame one byte per
//   transfer: 0xFF, 0xEE, sixteen payload bytes (each servo high byte then
//   low byte), fletcher sum A, fletcher sum B. last_byte marks sum B.
//   frames are not overlapped; the single byte
//   sequencer steps through the 20 frame positions one per cycle unless
//   stalled, the shared checksum adder takes one payload byte per step;
//   a new request is taken in the idle cycle after the final byte is loaded.
//   s_ready is low while a frame is being sent.
//   a taken request enters the send state, which then loads the first byte.
//   a stalled receiver (m_ready low) freezes the sequencer; the byte in the
//   output register holds until taken. the next request may be taken while
//   the final byte still waits in the output register.
//   reset (aresetn low, synchronous) empties the output register and returns
//   to idle. payload slots not refreshed by SERVO_COUNT keep earlier bytes.

module servo_frame_fletcher_packer #(
    parameter int unsigned SERVO_COUNT = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sffp_pkg::servo_set_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sffp_pkg::frame_out_t   m_data
);
    import sffp_pkg::*;

    localparam int unsigned WRITE_SLOTS =
        (SERVO_COUNT > FRAME_SLOTS) ? FRAME_SLOTS : SERVO_COUNT;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               m_valid_reg, m_valid_next;
    frame_out_t         m_data_reg, m_data_next;
    logic [BYTE_W-1:0]  pay_mem [PAY_BYTES];
    logic [BYTE_W-1:0]  pay_rd_reg;
    logic [SERVO_W-1:0] servo_in [FRAME_SLOTS];
    logic [PAY_W-1:0]   pay_rd_addr;
    logic [BYTE_W-1:0]  sel_byte;
    logic [BYTE_W-1:0]  sum_a, sum_b;
    logic               accept_in, load_out, in_payload;
    sum_ctrl_t          sum_ctrl;

    assign accept_in = s_valid && s_ready;
    assign load_out  = (state_reg == ST_SEND) && (!m_valid_reg || m_ready);
    assign in_payload = (idx_reg >= IDX_PAY_FIRST) && (idx_reg <= IDX_PAY_LAST);
    // read one step ahead so the byte is ready when the sequencer gets there
    assign pay_rd_addr = PAY_W'(idx_next - IDX_PAY_FIRST);

    assign servo_in[0] = s_data.servo_1;
    assign servo_in[1] = s_data.servo_2;
    assign servo_in[2] = s_data.servo_3;
    assign servo_in[3] = s_data.servo_4;
    assign servo_in[4] = s_data.servo_5;
    assign servo_in[5] = s_data.servo_6;
    assign servo_in[6] = s_data.servo_7;
    assign servo_in[7] = s_data.servo_8;

    // payload store, only the refreshed servo slots are written
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            for (int k = 0; k < WRITE_SLOTS; k++) begin
                pay_mem[PAY_W'(2*k)]   <= servo_in[k][SERVO_W-1:BYTE_W];
                pay_mem[PAY_W'(2*k+1)] <= servo_in[k][BYTE_W-1:0];
            end
        end
        pay_rd_reg <= pay_mem[pay_rd_addr];
    end

    always_comb begin
        case (idx_reg)
            IDX_SYNC_FIRST:  sel_byte = SYNC_FIRST;
            IDX_SYNC_SECOND: sel_byte = SYNC_SECOND;
            IDX_SUM_A:       sel_byte = sum_a;
            IDX_SUM_B:       sel_byte = sum_b;
            default:         sel_byte = pay_rd_reg;
        endcase
    end

    assign sum_ctrl.clear = accept_in;
    assign sum_ctrl.accum = load_out && in_payload;

    sffp_fletcher u_fletcher (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (sum_ctrl),
        .data_byte (sel_byte),
        .sum_a     (sum_a),
        .sum_b     (sum_b)
    );

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    state_next = ST_SEND;
                    idx_next   = IDX_SYNC_FIRST;
                end
            end
            ST_SEND: begin
                if (load_out) begin
                    m_valid_next           = 1'b1;
                    m_data_next.frame_byte = sel_byte;
                    m_data_next.last_byte  = (idx_reg == IDX_SUM_B);
                    if (idx_reg == IDX_SUM_B) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= IDX_SYNC_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_start_frame : assert property (@(posedge aclk) disable iff (!aresetn)
        accept_in |=> (state_reg == ST_SEND) && (idx_reg == IDX_SYNC_FIRST))
        else $error("frame did not start at the first sync byte");

    a_idx_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND) |-> (idx_reg <= IDX_SUM_B))
        else $error("byte index past end of frame");

    a_sync_out : assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && (idx_reg == IDX_SYNC_FIRST) |=>
            m_valid && (m_data.frame_byte == SYNC_FIRST) && !m_data.last_byte)
        else $error("first frame byte is not the sync byte");

    a_last_out : assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && (idx_reg == IDX_SUM_B) |=>
            m_valid && m_data.last_byte && (m_data.frame_byte == $past(sum_b)))
        else $error("final byte is not flagged checksum b");
`endif

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for servo_frame_fletcher_packer
// depends on sffp_pkg and the rtl; predicts each 20-byte frame with its fletcher sums

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sffp_pkg::*;

    localparam int unsigned SERVO_COUNT   = 8;
    localparam int unsigned ACTIVE_SERVOS =
        (SERVO_COUNT > FRAME_SLOTS) ? FRAME_SLOTS : SERVO_COUNT;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 30;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    servo_set_t  s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    frame_out_t  m_data;

    // predicted frame store and the bytes still to arrive
    logic [BYTE_W-1:0] frame_image [FRAME_LEN];
    frame_out_t        frame_bytes_due [$];
    frame_out_t        due_byte;
    int unsigned       mismatches = 0;
    logic              idling_on  = 1'b0;
    int unsigned       ready_hold = 0;

    servo_frame_fletcher_packer #(
        .SERVO_COUNT(SERVO_COUNT)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [SERVO_W-1:0] random_pulse();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return '1;
        end
        return SERVO_W'($urandom_range(0, 65535));
    endfunction

    function automatic servo_set_t random_servo_set();
        servo_set_t set;
        set.servo_1 = random_pulse();
        set.servo_2 = random_pulse();
        set.servo_3 = random_pulse();
        set.servo_4 = random_pulse();
        set.servo_5 = random_pulse();
        set.servo_6 = random_pulse();
        set.servo_7 = random_pulse();
        set.servo_8 = random_pulse();
        return set;
    endfunction

    // refresh the payload slots, run both sums over all sixteen payload bytes, queue the frame bytes
    function automatic void pack_frame(input servo_set_t set);
        logic [SERVO_W-1:0] servo_vals [FRAME_SLOTS];
        logic [BYTE_W-1:0]  sum_a;
        logic [BYTE_W-1:0]  sum_b;
        frame_out_t         entry;
        int                 pos;
        servo_vals = '{set.servo_1, set.servo_2, set.servo_3, set.servo_4,
                       set.servo_5, set.servo_6, set.servo_7, set.servo_8};
        for (int k = 0; k < ACTIVE_SERVOS; k++) begin
            pos = int'(IDX_PAY_FIRST) + 2 * k;
            frame_image[pos]     = servo_vals[k][SERVO_W-1:BYTE_W];
            frame_image[pos + 1] = servo_vals[k][BYTE_W-1:0];
        end
        sum_a = '0;
        sum_b = '0;
        for (int k = int'(IDX_PAY_FIRST); k <= int'(IDX_PAY_LAST); k++) begin
            sum_a = sum_a + frame_image[k];
            sum_b = sum_b + sum_a;
        end
        frame_image[IDX_SUM_A] = sum_a;
        frame_image[IDX_SUM_B] = sum_b;
        for (int k = 0; k < FRAME_LEN; k++) begin
            entry.frame_byte = frame_image[k];
            entry.last_byte  = (k == int'(IDX_SUM_B));
            frame_bytes_due.push_back(entry);
        end
    endfunction

    // called at a rising edge; returns at the edge that takes the request, or after a random gap when idling
    task automatic send_servo_set(input servo_set_t set);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= set;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pack_frame(set);
        gap = idling_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_frames_drained();
        while (frame_bytes_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // receiver back-pressure
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (idling_on && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_bytes_due.size() == 0) begin
                $display("%0t ns: unexpected byte, expected none, actual %h last %b",
                         $time, m_data.frame_byte, m_data.last_byte);
                mismatches++;
            end else begin
                due_byte = frame_bytes_due.pop_front();
                if (m_data.frame_byte !== due_byte.frame_byte) begin
                    $display("%0t ns: frame_byte expected %h actual %h",
                             $time, due_byte.frame_byte, m_data.frame_byte);
                    mismatches++;
                end
                if (m_data.last_byte !== due_byte.last_byte) begin
                    $display("%0t ns: last_byte expected %b actual %b",
                             $time, due_byte.last_byte, m_data.last_byte);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // field extremes, byte patterns and back-to-back requests, no idling
    task automatic test_directed();
        servo_set_t set;
        idling_on = 1'b0;
        send_servo_set('{default: 16'h0000});
        send_servo_set('{default: 16'hFFFF});
        send_servo_set('{default: 16'hAAAA});
        send_servo_set('{default: 16'h5555});
        send_servo_set('{default: 16'hFF00});
        send_servo_set('{default: 16'h00FF});
        send_servo_set('{16'h0102, 16'h0304, 16'h0506, 16'h0708,
                         16'h090A, 16'h0B0C, 16'h0D0E, 16'h0F10});
        send_servo_set('{16'h8000, 16'h0001, 16'h8000, 16'h0001,
                         16'h8000, 16'h0001, 16'h8000, 16'h0001});
        set = '0;
        set.servo_1 = 16'h0001;
        send_servo_set(set);
        set = '0;
        set.servo_8 = 16'hFFFF;
        send_servo_set(set);
        set = random_servo_set();
        send_servo_set(set);
        send_servo_set(set);
    endtask

    // sender holds off until the whole frame has been taken
    task automatic test_drain_pause();
        idling_on = 1'b1;
        repeat (8) begin
            send_servo_set(random_servo_set());
            s_valid <= 1'b0;
            wait_frames_drained();
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // random pulse widths, phases with and without idling
    task automatic test_random();
        for (int phase = 0; phase < 5; phase++) begin
            idling_on = (phase % 2 == 0);
            repeat (30) send_servo_set(random_servo_set());
        end
    endtask

    initial begin
        frame_image = '{default: '0};
        frame_image[IDX_SYNC_FIRST]  = SYNC_FIRST;
        frame_image[IDX_SYNC_SECOND] = SYNC_SECOND;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_drain_pause();
        test_random();

        s_valid <= 1'b0;
        idling_on = 1'b0;
        wait_frames_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (frame_bytes_due.size() != 0) begin
            $display("%0t ns: %0d frame bytes expected but never sent",
                     $time, frame_bytes_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sffp_pkg.sv
hdl/sffp_fletcher.sv
hdl/servo_frame_fletcher_packer.sv
verif/tb_top.sv
